// ----- hw/rtl/line_segment_intersect_core_defines.svh -----
// Assertion macros shared by the line segment intersection RTL.
// Define ASSERT_OFF to compile the checks out.
`ifndef LINE_SEGMENT_INTERSECT_CORE_DEFINES_SVH
`define LINE_SEGMENT_INTERSECT_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define LSI_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lsi check failed");
`define LSI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lsi check failed");
`else
`define LSI_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define LSI_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- hw/rtl/lsi_pkg.sv -----
// Shared types and constants for the line segment intersection core.
// No dependencies.
`timescale 1ns / 1ps
package lsi_pkg;
	localparam int unsigned COORD_WIDTH_DEF = 32;
	localparam int unsigned FRAC_BITS_DEF = 16;
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DIR_X = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DIR_Y = 2'd3;
	localparam logic [1:0] ST_VALID = 2'd0;
	localparam logic [1:0] ST_OUTSIDE = 2'd1;
	localparam logic [1:0] ST_NONE = 2'd2;
	localparam logic CMD_INTERSECT = 1'b0;
	localparam logic CMD_EVAL = 1'b1;
endpackage

// ----- hw/rtl/lsi_if.sv -----
// Valid/ready channel interface carrying one payload item.
// Depends on nothing; payload type is a parameter.
`timescale 1ns / 1ps
interface lsi_if #(parameter type payload_t = logic) ();
	logic valid;
	logic ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/lsi_div_cell.sv -----
// One restoring division cell: retires one quotient bit per clock while en
// is high and hands its partial remainder and side data to the next cell.
`timescale 1ns / 1ps
module lsi_div_cell import lsi_pkg::*; #(
	parameter int unsigned NW = 132,
	parameter int unsigned DW = 66,
	parameter int unsigned SW = 8,
	parameter int unsigned BIT = 0
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic v_in,
	input logic [NW-1:0] num_in,
	input logic [DW-1:0] den_in,
	input logic [DW:0] rem_in,
	input logic [NW-1:0] quo_in,
	input logic [SW-1:0] side_in,
	output logic v_s1,
	output logic [NW-1:0] num_s1,
	output logic [DW-1:0] den_s1,
	output logic [DW:0] rem_s1,
	output logic [NW-1:0] quo_s1,
	output logic [SW-1:0] side_s1
);
	logic [DW+1:0] sh;
	logic [DW+1:0] diff;
	logic [NW-1:0] quo_nx;
	always_comb begin
		sh = {rem_in, num_in[BIT]};
		diff = sh - {2'b00, den_in};
		quo_nx = quo_in;
		if (!diff[DW+1]) quo_nx[BIT] = 1'b1;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			num_s1 <= num_in;
			den_s1 <= den_in;
			side_s1 <= side_in;
			quo_s1 <= quo_nx;
			rem_s1 <= diff[DW+1] ? sh[DW:0] : diff[DW:0];
		end
	end
endmodule

// ----- hw/rtl/line_segment_intersect_core.sv -----
// Line against segment intersection and line evaluation, top level.
// Uses lsi_pkg, lsi_if, lsi_div_cell and the assertion macro header.
//
// One item enters on in_ch each cycle unless out_ch stalls, and one result leaves on out_ch.
// An item carries cmd, a segment's endpoints or a query x; the result
// carries status and a saturated Q16.16 point. base and direction are set
// through the write port (index 0..3). The user must write them only while
// the block is idle; the block does not enforce this. The pipeline holds
// a difference stage, a product stage, a determinant stage, a stage that
// forms the wide dividend from two partial products, a row of NB = 3*COORD_WIDTH+4
// restoring division cells for the x quotient, a second row for y, and the output
// register. Throughput is one item per cycle unless out_ch stalls; the chain of cells sets depth.
// Reset clears all valid bits and loads base 0, direction (1.0, 0).
// When out_ch stalls with a result waiting, the whole chain holds and
// in_ch.ready drops in the same cycle.
`timescale 1ns / 1ps
`include "line_segment_intersect_core_defines.svh"
module line_segment_intersect_core import lsi_pkg::*; #(
	parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [COORD_WIDTH-1:0] cfg_wdata,
	lsi_if.sink in_ch,
	lsi_if.source out_ch
);
	localparam int unsigned CW = COORD_WIDTH;
	localparam int unsigned DFW = CW + 1;
	localparam int unsigned PW = 2 * DFW + 1;
	localparam int unsigned NB = PW + CW + 1;
	localparam int unsigned DW = PW;
	localparam int unsigned SW = 2 + 4 * (CW + 1) + 2;

	logic signed [CW-1:0] base_x_q, base_y_q, dir_x_q, dir_y_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_x_q <= '0;
			base_y_q <= '0;
			dir_x_q <= CW'(1) << FRAC_BITS;
			dir_y_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BASE_X: base_x_q <= cfg_wdata;
				REG_BASE_Y: base_y_q <= cfg_wdata;
				REG_DIR_X: dir_x_q <= cfg_wdata;
				REG_DIR_Y: dir_y_q <= cfg_wdata;
				default: base_x_q <= base_x_q;
			endcase
		end
	end

	logic en;
	logic out_v_q;
	assign en = !out_v_q || out_ch.ready;
	assign in_ch.ready = en;
	logic acc;
	assign acc = in_ch.valid && en;

	// Stage 1: differences.
	logic v_s1, cmd_s1;
	logic signed [DFW-1:0] d2x_s1, d2y_s1, cx_s1, cy_s1;
	logic signed [CW-1:0] sx_s1, sy_s1, ex_s1, ey_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_ch.valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1 <= in_ch.data.cmd;
			sx_s1 <= in_ch.data.start_x;
			sy_s1 <= in_ch.data.start_y;
			ex_s1 <= in_ch.data.end_x;
			ey_s1 <= in_ch.data.end_y;
			d2x_s1 <= DFW'(in_ch.data.end_x) - DFW'(in_ch.data.start_x);
			d2y_s1 <= DFW'(in_ch.data.end_y) - DFW'(in_ch.data.start_y);
			cx_s1 <= DFW'(in_ch.data.start_x) - DFW'(base_x_q);
			cy_s1 <= DFW'(in_ch.data.start_y) - DFW'(base_y_q);
		end
	end

	// Stage 2: four products. In eval mode num = cx, den = dir_x.
	logic v_s2, cmd_s2;
	logic signed [PW-1:0] p1_s2, p2_s2, p3_s2, p4_s2;
	logic signed [CW-1:0] sx_s2, sy_s2, ex_s2, ey_s2;
	logic signed [DFW-1:0] cx_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s2 <= cmd_s1;
			sx_s2 <= sx_s1;
			sy_s2 <= sy_s1;
			ex_s2 <= ex_s1;
			ey_s2 <= ey_s1;
			cx_s2 <= cx_s1;
			p1_s2 <= PW'(d2x_s1) * PW'(dir_y_q);
			p2_s2 <= PW'(dir_x_q) * PW'(d2y_s1);
			p3_s2 <= PW'(d2x_s1) * PW'(cy_s1);
			p4_s2 <= PW'(cx_s1) * PW'(d2y_s1);
		end
	end

	// Stage 3: det, num and magnitudes for the divider.
	logic v_s3, cmd_s3, zero_s3, nneg_s3, dneg_s3;
	logic [PW-1:0] nabs_s3, dabs_s3;
	logic signed [CW-1:0] sx_s3, sy_s3, ex_s3, ey_s3;
	logic signed [PW-1:0] det_c, num_c, nsel_c, dsel_c;
	always_comb begin
		det_c = p1_s2 - p2_s2;
		num_c = p3_s2 - p4_s2;
		if (cmd_s2 == CMD_EVAL) begin
			nsel_c = PW'(cx_s2);
			dsel_c = PW'(dir_x_q);
		end else begin
			nsel_c = num_c;
			dsel_c = det_c;
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s3 <= cmd_s2;
			sx_s3 <= sx_s2;
			sy_s3 <= sy_s2;
			ex_s3 <= ex_s2;
			ey_s3 <= ey_s2;
			zero_s3 <= (dsel_c == '0);
			nneg_s3 <= nsel_c[PW-1];
			dneg_s3 <= dsel_c[PW-1];
			nabs_s3 <= nsel_c[PW-1] ? PW'(-nsel_c) : nsel_c;
			dabs_s3 <= dsel_c[PW-1] ? PW'(-dsel_c) : dsel_c;
		end
	end

	// Stage 4: |num|*|dir| as two partial products per axis.
	localparam int unsigned NWW = NB;
	localparam int unsigned LW = (PW + 1) / 2;
	localparam int unsigned HW = PW - LW;
	localparam int unsigned LPW = LW + CW;
	localparam int unsigned HPW = HW + CW;
	logic [CW-1:0] adx, ady;
	logic [SW-1:0] side_in;
	logic v_s4;
	logic [DW-1:0] dabs_s4;
	logic [SW-1:0] side_s4;
	logic [LPW-1:0] mxl_s4, myl_s4;
	logic [HPW-1:0] mxh_s4, myh_s4;
	logic [NWW-1:0] nx_c, ny_c;
	always_comb begin
		adx = dir_x_q[CW-1] ? CW'(-dir_x_q) : CW'(dir_x_q);
		ady = dir_y_q[CW-1] ? CW'(-dir_y_q) : CW'(dir_y_q);
	end
	assign side_in = {cmd_s3, zero_s3, sx_s3, 1'b0, sy_s3, 1'b0, ex_s3, 1'b0,
		ey_s3, 1'b0, nneg_s3 ^ dir_x_q[CW-1] ^ dneg_s3,
		nneg_s3 ^ dir_y_q[CW-1] ^ dneg_s3};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			dabs_s4 <= dabs_s3;
			side_s4 <= side_in;
			mxl_s4 <= LPW'(nabs_s3[LW-1:0]) * LPW'(adx);
			mxh_s4 <= HPW'(nabs_s3[PW-1:LW]) * HPW'(adx);
			myl_s4 <= LPW'(nabs_s3[LW-1:0]) * LPW'(ady);
			myh_s4 <= HPW'(nabs_s3[PW-1:LW]) * HPW'(ady);
		end
	end
	always_comb begin
		nx_c = NWW'(mxl_s4) + (NWW'(mxh_s4) << LW);
		ny_c = NWW'(myl_s4) + (NWW'(myh_s4) << LW);
	end

	// Two rows of cells: |num*dir| / |den| for x then y.
	logic v_a [0:NB];
	logic [NWW-1:0] n_a [0:NB];
	logic [DW-1:0] d_a [0:NB];
	logic [DW:0] r_a [0:NB];
	logic [NWW-1:0] q_a [0:NB];
	logic [SW+NWW-1:0] s_a [0:NB];
	assign v_a[0] = v_s4;
	assign n_a[0] = nx_c;
	assign d_a[0] = dabs_s4;
	assign r_a[0] = '0;
	assign q_a[0] = '0;
	assign s_a[0] = {side_s4, ny_c};
	for (genvar g = 0; g < NB; g++) begin : g_rowx
		lsi_div_cell #(.NW(NWW), .DW(DW), .SW(SW + NWW), .BIT(NB - 1 - g)) u_cell (
			.clk, .arst_n, .en, .v_in(v_a[g]), .num_in(n_a[g]), .den_in(d_a[g]),
			.rem_in(r_a[g]), .quo_in(q_a[g]), .side_in(s_a[g]),
			.v_s1(v_a[g+1]), .num_s1(n_a[g+1]), .den_s1(d_a[g+1]),
			.rem_s1(r_a[g+1]), .quo_s1(q_a[g+1]), .side_s1(s_a[g+1]));
	end

	localparam int unsigned SW2 = SW + NWW;
	logic v_b [0:NB];
	logic [NWW-1:0] n_b [0:NB];
	logic [DW-1:0] d_b [0:NB];
	logic [DW:0] r_b [0:NB];
	logic [NWW-1:0] q_b [0:NB];
	logic [SW2-1:0] s_b [0:NB];
	assign v_b[0] = v_a[NB];
	assign n_b[0] = s_a[NB][NWW-1:0];
	assign d_b[0] = d_a[NB];
	assign r_b[0] = '0;
	assign q_b[0] = '0;
	assign s_b[0] = {s_a[NB][SW+NWW-1:NWW], q_a[NB]};
	for (genvar g = 0; g < NB; g++) begin : g_rowy
		lsi_div_cell #(.NW(NWW), .DW(DW), .SW(SW2), .BIT(NB - 1 - g)) u_cell (
			.clk, .arst_n, .en, .v_in(v_b[g]), .num_in(n_b[g]), .den_in(d_b[g]),
			.rem_in(r_b[g]), .quo_in(q_b[g]), .side_in(s_b[g]),
			.v_s1(v_b[g+1]), .num_s1(n_b[g+1]), .den_s1(d_b[g+1]),
			.rem_s1(r_b[g+1]), .quo_s1(q_b[g+1]), .side_s1(s_b[g+1]));
	end

	// Final stage: sign, clamp, add base, box test, saturate.
	localparam int unsigned EW = CW + 3;
	logic [SW-1:0] sd;
	logic [NWW-1:0] qx, qy;
	logic f_cmd, f_zero, f_sx, f_sy;
	logic signed [CW-1:0] f_stx, f_sty, f_enx, f_eny;
	logic signed [EW-1:0] offx, offy, ix, iy, hi, lo;
	logic signed [EW-1:0] xlo, xhi, ylo, yhi;
	logic [1:0] st_c;
	logic signed [CW-1:0] ox_c, oy_c;
	localparam logic [NWW-1:0] LIM = NWW'(1) << (CW + 1);

	function automatic logic signed [EW-1:0] clampq(input logic [NWW-1:0] q,
			input logic neg);
		logic [NWW-1:0] m;
		m = (q > LIM) ? LIM : q;
		return neg ? EW'(-$signed({1'b0, m[EW-2:0]})) : EW'({1'b0, m[EW-2:0]});
	endfunction

	always_comb begin
		sd = s_b[NB][SW2-1:NWW];
		qx = s_b[NB][NWW-1:0];
		qy = q_b[NB];
		f_cmd = sd[SW-1];
		f_zero = sd[SW-2];
		f_stx = sd[SW-3 -: CW];
		f_sty = sd[SW-4-CW -: CW];
		f_enx = sd[SW-5-2*CW -: CW];
		f_eny = sd[SW-6-3*CW -: CW];
		f_sx = sd[1];
		f_sy = sd[0];
		offx = clampq(qx, f_sx);
		offy = clampq(qy, f_sy);
		ix = EW'(base_x_q) + offx;
		iy = EW'(base_y_q) + offy;
		hi = EW'({1'b0, {(CW-1){1'b1}}});
		lo = -hi - EW'(1);
		xlo = (f_stx < f_enx) ? EW'(f_stx) : EW'(f_enx);
		xhi = (f_stx < f_enx) ? EW'(f_enx) : EW'(f_stx);
		ylo = (f_sty < f_eny) ? EW'(f_sty) : EW'(f_eny);
		yhi = (f_sty < f_eny) ? EW'(f_eny) : EW'(f_sty);
		ox_c = (ix > hi) ? hi[CW-1:0] : ((ix < lo) ? lo[CW-1:0] : ix[CW-1:0]);
		oy_c = (iy > hi) ? hi[CW-1:0] : ((iy < lo) ? lo[CW-1:0] : iy[CW-1:0]);
		if (f_cmd == CMD_EVAL) begin
			if (f_zero) begin
				st_c = ST_NONE;
				oy_c = '0;
			end else begin
				st_c = ST_VALID;
			end
			ox_c = f_stx;
		end else if (f_zero) begin
			st_c = ST_NONE;
			ox_c = '0;
			oy_c = '0;
		end else if (ix >= xlo && ix <= xhi && iy >= ylo && iy <= yhi) begin
			st_c = ST_VALID;
		end else begin
			st_c = ST_OUTSIDE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (en) out_v_q <= v_b[NB];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			out_ch.data.status <= st_c;
			out_ch.data.point_x <= ox_c;
			out_ch.data.point_y <= oy_c;
		end
	end
	assign out_ch.valid = out_v_q;

	`LSI_ASSERT_IMPL(a_stall_blocks_in, clk, arst_n, out_v_q && !out_ch.ready, !in_ch.ready)
	`LSI_ASSERT_NEXT(a_first_stage, clk, arst_n, acc, v_s1)
	`LSI_ASSERT_IMPL(a_status_code, clk, arst_n, out_v_q,
		out_ch.data.status == ST_VALID || out_ch.data.status == ST_OUTSIDE ||
		out_ch.data.status == ST_NONE)
endmodule
